/* hdl/interval_schedule_query_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the interval schedule query block
// Concurrent checks, clocked on clk and disabled during rst. They are empty
// in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SCHEDULE_QUERY_TOP_ASSERT_SVH
`define INTERVAL_SCHEDULE_QUERY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define ISQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ISQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ISQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ISQ_ASSERT(label, cond, msg)
`define ISQ_ASSERT_IMP(label, ante, cons, msg)
`define ISQ_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

/* hdl/isq_pkg.sv */
// ----------------------------------------------------------------------------
// isq_pkg: shared types and constants
// Mode codes, sequencer states and default sizes for the interval schedule
// query block.
// ----------------------------------------------------------------------------
package isq_pkg;

  localparam int MAX_MEETINGS_DEF = 256;
  localparam int TIME_BITS_DEF    = 32;

  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 9;
  localparam int OUT_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2
  } isq_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_QRY_RD,
    ST_QRY_CMP,
    ST_RESP
  } isq_state_t;

endpackage

/* hdl/isq_ram.sv */
// ----------------------------------------------------------------------------
// isq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module isq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/interval_schedule_query_top.sv */
// ----------------------------------------------------------------------------
// interval_schedule_query_top: greedy interval selection over a sorted table
// Keeps intervals sorted by end, then start, in one RAM. Inserts shift the
// table up one entry a cycle; queries walk it once and count the intervals
// a greedy earliest-end selection takes inside the window.
//
//   Channel | Direction | Fields (lowest bit first)
//   s_axis  | in        | tuser: mode; tdata: time_a, time_b
//   m_axis  | out       | tdata: chosen_count, status
//
// A clear gives no item and leaves the block ready. After it is accepted, an
// insert walks down from the top entry to its sorted position (it goes straight
// to the write on an empty table and to the response on a full one); a query
// walks every entry (straight to the response on an empty table). No new item
// is taken during a walk. The single RAM read port carries both walks, one
// entry a cycle. Reset empties the table at once; there is no clearing pass.
// A new item is taken while a result waits on m_axis, but the next result holds
// in ST_RESP until the waiting one is taken.
// ----------------------------------------------------------------------------
module interval_schedule_query_top #(
  parameter int MAX_MEETINGS = isq_pkg::MAX_MEETINGS_DEF,
  parameter int TIME_BITS    = isq_pkg::TIME_BITS_DEF,
  localparam int IN_DATA_W   = ((2 * TIME_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [isq_pkg::MODE_W-1:0]    s_axis_tuser,   // mode
  input  logic [IN_DATA_W-1:0]          s_axis_tdata,   // time_a, time_b
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [isq_pkg::OUT_DATA_W-1:0] m_axis_tdata   // chosen_count, status
);

  localparam int IDX_W   = $clog2(MAX_MEETINGS);
  localparam int CNT_W   = $clog2(MAX_MEETINGS + 1);
  localparam int ENTRY_W = 2 * TIME_BITS;
  localparam int PAD_W   = isq_pkg::OUT_DATA_W - isq_pkg::COUNT_W - 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_MEETINGS);

  isq_pkg::isq_state_t state, state_next;

  logic [CNT_W-1:0]            count, count_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [TIME_BITS-1:0]        key_start, key_start_next;  // window start, then last end taken, in a query
  logic [TIME_BITS-1:0]        key_end, key_end_next;      // window end in a query
  logic [isq_pkg::COUNT_W-1:0] taken, taken_next;
  logic                        res_status, res_status_next;
  logic                        out_valid, out_valid_next;
  logic [isq_pkg::COUNT_W-1:0] out_count, out_count_next;
  logic                        out_status, out_status_next;

  logic                 rd_en, wr_en;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [ENTRY_W-1:0]   wr_data, rd_data;
  logic [TIME_BITS-1:0] in_start, in_end, rd_start, rd_end;
  logic [CNT_W-1:0]     count_m1;
  logic                 accept, out_free, entry_after, entry_taken, idx_last;

  assign in_start = s_axis_tdata[TIME_BITS-1:0];
  assign in_end   = s_axis_tdata[ENTRY_W-1:TIME_BITS];
  assign rd_start = rd_data[TIME_BITS-1:0];
  assign rd_end   = rd_data[ENTRY_W-1:TIME_BITS];

  assign s_axis_tready = (state == isq_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign count_m1      = count - CNT_W'(1);
  assign idx_last      = (CNT_W'(idx) == count_m1);

  // The stored entry must move above the new one.
  assign entry_after = (rd_end > key_end) || ((rd_end == key_end) && (rd_start > key_start));
  assign entry_taken = (rd_start >= key_start) && (rd_end <= key_end);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_status, out_count};

  isq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MEETINGS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      isq_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            isq_pkg::MODE_INSERT: begin
              if (count == FULL) begin
                state_next = isq_pkg::ST_RESP;
              end else if (count == '0) begin
                state_next = isq_pkg::ST_INS_PUT;
              end else begin
                state_next = isq_pkg::ST_INS_RD;
              end
            end
            isq_pkg::MODE_QUERY: begin
              state_next = (count == '0) ? isq_pkg::ST_RESP : isq_pkg::ST_QRY_RD;
            end
            default: state_next = isq_pkg::ST_IDLE;
          endcase
        end
      end
      isq_pkg::ST_INS_RD: state_next = isq_pkg::ST_INS_CMP;
      isq_pkg::ST_INS_CMP: begin
        if (!entry_after) begin
          state_next = isq_pkg::ST_RESP;
        end else if (idx == '0) begin
          state_next = isq_pkg::ST_INS_PUT;
        end
      end
      isq_pkg::ST_INS_PUT: state_next = isq_pkg::ST_RESP;
      isq_pkg::ST_QRY_RD:  state_next = isq_pkg::ST_QRY_CMP;
      isq_pkg::ST_QRY_CMP: begin
        if (idx_last) begin
          state_next = isq_pkg::ST_RESP;
        end
      end
      isq_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = isq_pkg::ST_IDLE;
        end
      end
      default: state_next = isq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = {key_end, key_start};
    count_next      = count;
    idx_next        = idx;
    key_start_next  = key_start;
    key_end_next    = key_end;
    taken_next      = taken;
    res_status_next = res_status;
    out_valid_next  = out_valid && !m_axis_tready;
    out_count_next  = out_count;
    out_status_next = out_status;

    unique case (state)
      isq_pkg::ST_IDLE: begin
        if (accept) begin
          key_start_next  = in_start;
          key_end_next    = in_end;
          taken_next      = '0;
          res_status_next = 1'b0;
          unique case (s_axis_tuser)
            isq_pkg::MODE_CLEAR: count_next = '0;
            isq_pkg::MODE_INSERT: begin
              res_status_next = (count == FULL);
              idx_next        = (count == '0) ? '0 : count_m1[IDX_W-1:0];
            end
            isq_pkg::MODE_QUERY: idx_next = '0;
            default: ;
          endcase
        end
      end
      isq_pkg::ST_INS_RD: rd_en = 1'b1;
      isq_pkg::ST_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx + IDX_W'(1);
        if (entry_after) begin
          wr_data = rd_data;
          if (idx != '0) begin
            rd_en    = 1'b1;
            rd_addr  = idx - IDX_W'(1);
            idx_next = idx - IDX_W'(1);
          end
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      isq_pkg::ST_INS_PUT: begin
        wr_en      = 1'b1;
        count_next = count + CNT_W'(1);
      end
      isq_pkg::ST_QRY_RD: rd_en = 1'b1;
      isq_pkg::ST_QRY_CMP: begin
        if (entry_taken) begin
          key_start_next = rd_end;
          if (taken != isq_pkg::COUNT_MAX) begin
            taken_next = taken + isq_pkg::COUNT_W'(1);
          end
        end
        if (!idx_last) begin
          rd_en    = 1'b1;
          rd_addr  = idx + IDX_W'(1);
          idx_next = idx + IDX_W'(1);
        end
      end
      isq_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_count_next  = taken;
          out_status_next = res_status;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isq_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key_start  <= key_start_next;
    key_end    <= key_end_next;
    taken      <= taken_next;
    res_status <= res_status_next;
    out_count  <= out_count_next;
    out_status <= out_status_next;
  end

`include "interval_schedule_query_top_assert.svh"

  `ISQ_ASSERT(a_count_range, count <= FULL, "entry count above table size")
  `ISQ_ASSERT_IMP(a_walk_in_table, rd_en && (state == isq_pkg::ST_QRY_CMP),
                  CNT_W'(rd_addr) < count, "query read beyond table")
  `ISQ_ASSERT_NXT(a_insert_busy, accept && (s_axis_tuser == isq_pkg::MODE_INSERT),
                  state != isq_pkg::ST_IDLE, "insert did not start")
  `ISQ_ASSERT_IMP(a_taken_bound, state == isq_pkg::ST_QRY_CMP,
                  32'(taken) <= 32'(count), "taken count above entry count")
  `ISQ_ASSERT_IMP(a_write_in_table, wr_en, CNT_W'(wr_addr) <= count,
                  "table write leaves a gap")

endmodule
